// ===== design/tvsynth_pkg.sv =====
// Package for the three-voice sine chord synthesizer.
// Holds widths, parameter defaults, shared types and the quarter-wave sine entry function.
// No dependencies.
package tvsynth_pkg;

  // Parameter defaults
  localparam int unsigned VOICES_DEF          = 3;
  localparam int unsigned PHASE_BITS_DEF      = 32;
  localparam int unsigned TABLE_ADDR_BITS_DEF = 10;

  // Field widths
  localparam int unsigned STEP_W    = 31;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned Q15_W     = 15;
  localparam int unsigned IN_VOICES = 3;
  localparam int unsigned TDATA_W   = 96;

  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q15_MAX     = 64'd32767;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [STEP_W-1:0]          step_t;

  // Per-lane pipeline control
  typedef struct packed {
    logic en;     // pipeline advances this cycle
    logic load;   // an input transaction is taken this cycle
    logic start;  // note start flag of that transaction
  } lane_ctl_t;

  // Quarter-wave sine in Q15 at point k of 2^addr_bits, fixed-point Taylor form.
  // Only evaluated at elaboration to fill the lane ROMs.
  function automatic logic [Q15_W-1:0] qsine_entry(input logic [63:0] k,
                                                   input int unsigned addr_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] q;
    x  = (k * HALF_PI_Q30) >> addr_bits;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    q  = (s * Q15_MAX + (Q30_ONE >> 1)) >> 30;
    if (q > Q15_MAX) begin
      q = Q15_MAX;
    end
    return q[Q15_W-1:0];
  endfunction

endpackage

// ===== design/tvsynth_lane.sv =====
// One oscillator lane: phase accumulator, quarter-wave ROM lookup and sign fold.
// Depends on tvsynth_pkg.
module tvsynth_lane #(
  parameter int unsigned PHASE_BITS      = tvsynth_pkg::PHASE_BITS_DEF,
  parameter int unsigned TABLE_ADDR_BITS = tvsynth_pkg::TABLE_ADDR_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tvsynth_pkg::lane_ctl_t ctl_i,
  input  tvsynth_pkg::step_t     step_i,
  output tvsynth_pkg::sample_t   value_o
);
  import tvsynth_pkg::*;

  localparam int unsigned RomDepth = (1 << TABLE_ADDR_BITS) + 1;
  localparam logic [TABLE_ADDR_BITS:0] QuarterN = {1'b1, {TABLE_ADDR_BITS{1'b0}}};

  typedef logic [Q15_W-1:0] rom_arr_t [RomDepth];

  function automatic rom_arr_t build_rom();
    rom_arr_t r;
    for (int k = 0; k < RomDepth; k++) begin
      r[k] = qsine_entry(64'(k), TABLE_ADDR_BITS);
    end
    return r;
  endfunction

  localparam rom_arr_t QsineRom = build_rom();

  logic [PHASE_BITS-1:0]      phase_q, phase_d;
  logic [PHASE_BITS-1:0]      ph_use;
  logic [PHASE_BITS-1:0]      inc;
  logic [1:0]                 quad;
  logic [TABLE_ADDR_BITS-1:0] idx;
  logic [TABLE_ADDR_BITS:0]   addr;
  logic [Q15_W-1:0]           rom_q;
  logic                       neg_q;
  logic                       act_q;
  sample_t                    val_q;
  sample_t                    mag;

  // Increment wraps modulo the phase width
  assign inc = PHASE_BITS'(step_i);

  // Phase used this sample, table address with quadrant mirroring
  always_comb begin
    ph_use  = ctl_i.start ? '0 : phase_q;
    quad    = ph_use[PHASE_BITS-1 -: 2];
    idx     = ph_use[PHASE_BITS-3 -: TABLE_ADDR_BITS];
    addr    = quad[0] ? (QuarterN - {1'b0, idx}) : {1'b0, idx};
    phase_d = ph_use + inc;
  end

  // Phase accumulator, advances once per accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (ctl_i.load) begin
      phase_q <= phase_d;
    end
  end

  // ROM read stage
  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      rom_q <= QsineRom[addr];
      neg_q <= quad[1];
      act_q <= |step_i;
    end
  end

  // Sign fold and mute of silent voices
  assign mag = sample_t'({1'b0, rom_q});

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      val_q <= act_q ? (neg_q ? -mag : mag) : '0;
    end
  end

  assign value_o = val_q;

endmodule

// ===== design/tvsynth_mix.sv =====
// Merge stage: sums the lane values and divides by the voice count toward zero.
// Depends on tvsynth_pkg.
module tvsynth_mix #(
  parameter int unsigned VOICES = tvsynth_pkg::VOICES_DEF
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  tvsynth_pkg::sample_t lane_val_i [VOICES],
  output tvsynth_pkg::sample_t sample_o
);
  import tvsynth_pkg::*;

  localparam int unsigned VoiceLog = $clog2(VOICES);
  localparam int unsigned SumW     = SAMPLE_W + VoiceLog;
  localparam int unsigned AbsW     = SumW - 1;
  // Reciprocal exact for every magnitude below 2^AbsW
  localparam int unsigned Shift    = AbsW + VoiceLog;
  localparam int unsigned RecipW   = Shift + 1;
  localparam int unsigned ProdW    = AbsW + RecipW;
  localparam logic [RecipW-1:0] Recip =
    RecipW'(((64'd1 << Shift) + 64'(VOICES) - 64'd1) / 64'(VOICES));

  logic signed [SumW-1:0] sum_d, sum_q;
  logic [AbsW-1:0]        mag;
  logic [ProdW-1:0]       prod_q;
  logic                   neg_q;
  sample_t                quo;
  sample_t                sample_q;

  // Sum of all lanes
  always_comb begin
    sum_d = '0;
    for (int v = 0; v < VOICES; v++) begin
      sum_d = sum_d + SumW'(lane_val_i[v]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_d;
    end
  end

  // Magnitude times reciprocal
  assign mag = sum_q[SumW-1] ? AbsW'(-sum_q) : AbsW'(sum_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= ProdW'(mag) * ProdW'(Recip);
      neg_q  <= sum_q[SumW-1];
    end
  end

  // Restore sign, output register
  assign quo = sample_t'(prod_q[Shift +: SAMPLE_W]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sample_q <= neg_q ? -quo : quo;
    end
  end

  assign sample_o = sample_q;

endmodule

// ===== design/three_voice_sine_chord_synth_top.sv =====
// Top level of the three-voice sine chord synthesizer: stream ports, lanes, mixer.
// Depends on tvsynth_pkg, tvsynth_lane and tvsynth_mix.
//
//   channel | direction | tdata                         | tuser
//   s_axis  | in        | step_voice_a, _b, _c (31 each) | note_start
//   m_axis  | out       | sample_out (16, signed)        | -
//
// One transaction per cycle is accepted unless the output stalls; a result passes the
// ROM read, sign-fold, mixer sum, product and output registers. Each lane reads its own
// quarter-wave ROM once per cycle while the pipeline advances, and the lanes plus mixer
// form one pipeline that advances together. A stalled output freezes the whole pipeline;
// s_axis_tready_o is low only while a result is held and m_axis_tready_i is low.
// Reset clears the phase accumulators and all valid flags.
module three_voice_sine_chord_synth_top #(
  parameter int unsigned VOICES          = tvsynth_pkg::VOICES_DEF,
  parameter int unsigned PHASE_BITS      = tvsynth_pkg::PHASE_BITS_DEF,
  parameter int unsigned TABLE_ADDR_BITS = tvsynth_pkg::TABLE_ADDR_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [30:0] step_voice_a, [61:31] step_voice_b, [92:62] step_voice_c, [95:93] zero
  input  logic [tvsynth_pkg::TDATA_W-1:0]   s_axis_tdata_i,
  // [0] note_start
  input  logic                              s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [15:0] sample_out
  output logic [tvsynth_pkg::SAMPLE_W-1:0]  m_axis_tdata_o
);
  import tvsynth_pkg::*;

  localparam int unsigned Stages = 5;

  logic              en;
  logic              load;
  logic [Stages-1:0] vld_q;
  lane_ctl_t         ctl;
  step_t             steps    [VOICES];
  sample_t           lane_val [VOICES];
  sample_t           sample;

  // Pipeline advance and input handshake
  assign en              = !vld_q[Stages-1] || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign load            = s_axis_tvalid_i && en;

  assign ctl.en    = en;
  assign ctl.load  = load;
  assign ctl.start = s_axis_tuser_i;

  // Valid flags travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Stages-2:0], s_axis_tvalid_i};
    end
  end

  // Oscillator lanes; voices without an input field stay silent
  for (genvar v = 0; v < VOICES; v++) begin : g_lane
    if (v < IN_VOICES) begin : g_fed
      assign steps[v] = s_axis_tdata_i[v*STEP_W +: STEP_W];
    end else begin : g_mute
      assign steps[v] = '0;
    end

    tvsynth_lane #(
      .PHASE_BITS      (PHASE_BITS),
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .step_i  (steps[v]),
      .value_o (lane_val[v])
    );
  end

  // Mixer and output register
  tvsynth_mix #(
    .VOICES (VOICES)
  ) u_mix (
    .clk_i      (clk_i),
    .en_i       (en),
    .lane_val_i (lane_val),
    .sample_o   (sample)
  );

  assign m_axis_tvalid_o = vld_q[Stages-1];
  assign m_axis_tdata_o  = sample;

endmodule
